@@ hdl/tvi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_pkg
// Shared rule codes and result source selects for the truth-value inference
// unit.
// ----------------------------------------------------------------------------
package tvi_pkg;

    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_DEDUCE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REVISE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ABDUCE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INDUCE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TEMPORAL = 3'd4;

    localparam int SRC_W = 2;

    // confidence source at the output stage
    localparam logic [SRC_W-1:0] SRC_DIRECT = 2'd0;
    localparam logic [SRC_W-1:0] SRC_DIV    = 2'd1;
    localparam logic [SRC_W-1:0] SRC_DECAY  = 2'd2;

endpackage

@@ hdl/tvi_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_req_if / tvi_rsp_if
// Valid/ready channels carrying inference requests and truth-value results.
// ----------------------------------------------------------------------------
interface tvi_req_if #(
    parameter int FRAC_BITS = 16,
    parameter int STEP_BITS = 8
);
    logic                        valid;
    logic                        ready;
    logic [tvi_pkg::CMD_W-1:0]   cmd;
    logic [FRAC_BITS:0]          a_strength;
    logic [FRAC_BITS:0]          a_confidence;
    logic [FRAC_BITS:0]          b_strength;
    logic [FRAC_BITS:0]          b_confidence;
    logic [FRAC_BITS:0]          ab_strength;
    logic [FRAC_BITS:0]          ab_confidence;
    logic [STEP_BITS-1:0]        step_count;
    logic [FRAC_BITS:0]          decay_rate;

    modport source (
        output valid, cmd, a_strength, a_confidence, b_strength, b_confidence,
               ab_strength, ab_confidence, step_count, decay_rate,
        input  ready
    );
    modport sink (
        input  valid, cmd, a_strength, a_confidence, b_strength, b_confidence,
               ab_strength, ab_confidence, step_count, decay_rate,
        output ready
    );
endinterface

interface tvi_rsp_if #(
    parameter int FRAC_BITS = 16
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] out_strength;
    logic [FRAC_BITS:0] out_confidence;

    modport source (output valid, out_strength, out_confidence, input ready);
    modport sink   (input  valid, out_strength, out_confidence, output ready);
endinterface

@@ hdl/tvi_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_chain
// Long pipeline: up to one decay multiply and one quotient bit of each of two
// restoring dividers per stage; side payload rides along.
// ----------------------------------------------------------------------------
module tvi_chain #(
    parameter int FRAC_BITS = 16,
    parameter int STEP_BITS = 8,
    parameter int SIDE_W    = 38
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [STEP_BITS-1:0]   in_steps,
    input  logic [FRAC_BITS:0]     in_decay,
    input  logic [FRAC_BITS+1:0]   in_rem_s,
    input  logic [FRAC_BITS+1:0]   in_den_s,
    input  logic [FRAC_BITS+1:0]   in_lo_s,
    input  logic [FRAC_BITS+1:0]   in_rem_c,
    input  logic [FRAC_BITS+1:0]   in_den_c,
    input  logic [FRAC_BITS+1:0]   in_lo_c,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output logic [FRAC_BITS:0]     out_f,
    output logic [FRAC_BITS+1:0]   out_q_s,
    output logic [FRAC_BITS+1:0]   out_q_c,
    output logic [SIDE_W-1:0]      out_side
);
    localparam int F     = FRAC_BITS;
    localparam int W     = FRAC_BITS + 1;
    localparam int DW    = FRAC_BITS + 2;
    localparam int QW    = FRAC_BITS + 2;
    localparam int NSTEP = (1 << STEP_BITS) - 1;
    localparam int L     = (NSTEP > QW) ? NSTEP : QW;
    localparam logic [W-1:0] ONE = W'(1) << F;

    logic                 v_reg    [0:L-1];
    logic [STEP_BITS-1:0] st_reg   [0:L-1];
    logic [W-1:0]         dec_reg  [0:L-1];
    logic [W-1:0]         f_reg    [0:L-1];
    logic [DW-1:0]        rs_reg   [0:L-1];
    logic [DW-1:0]        ds_reg   [0:L-1];
    logic [QW-1:0]        ls_reg   [0:L-1];
    logic [QW-1:0]        qs_reg   [0:L-1];
    logic [DW-1:0]        rc_reg   [0:L-1];
    logic [DW-1:0]        dc_reg   [0:L-1];
    logic [QW-1:0]        lc_reg   [0:L-1];
    logic [QW-1:0]        qc_reg   [0:L-1];
    logic [SIDE_W-1:0]    sd_reg   [0:L-1];

    for (genvar k = 0; k < L; k++)
    begin : g_stage
        logic                 v_src;
        logic [STEP_BITS-1:0] st_src;
        logic [W-1:0]         dec_src;
        logic [W-1:0]         f_src;
        logic [DW-1:0]        rs_src, ds_src, rc_src, dc_src;
        logic [QW-1:0]        ls_src, qs_src, lc_src, qc_src;
        logic [SIDE_W-1:0]    sd_src;
        logic [W-1:0]         f_next;
        logic [DW-1:0]        rs_next, rc_next;
        logic [QW-1:0]        qs_next, qc_next;

        if (k == 0)
        begin : g_head
            assign v_src   = in_valid;
            assign st_src  = in_steps;
            assign dec_src = in_decay;
            assign f_src   = ONE;
            assign rs_src  = in_rem_s;
            assign ds_src  = in_den_s;
            assign ls_src  = in_lo_s;
            assign qs_src  = '0;
            assign rc_src  = in_rem_c;
            assign dc_src  = in_den_c;
            assign lc_src  = in_lo_c;
            assign qc_src  = '0;
            assign sd_src  = in_side;
        end
        else
        begin : g_body
            assign v_src   = v_reg[k-1];
            assign st_src  = st_reg[k-1];
            assign dec_src = dec_reg[k-1];
            assign f_src   = f_reg[k-1];
            assign rs_src  = rs_reg[k-1];
            assign ds_src  = ds_reg[k-1];
            assign ls_src  = ls_reg[k-1];
            assign qs_src  = qs_reg[k-1];
            assign rc_src  = rc_reg[k-1];
            assign dc_src  = dc_reg[k-1];
            assign lc_src  = lc_reg[k-1];
            assign qc_src  = qc_reg[k-1];
            assign sd_src  = sd_reg[k-1];
        end

        if (k < NSTEP)
        begin : g_decay
            logic [2*W-1:0] prod;
            always_comb
            begin
                prod   = (2*W)'(f_src) * (2*W)'(dec_src);
                f_next = (st_src > STEP_BITS'(k)) ? prod[F+W-1:F] : f_src;
            end
        end
        else
        begin : g_nodecay
            assign f_next = f_src;
        end

        if (k < QW)
        begin : g_div
            localparam int BI = QW - 1 - k;
            logic [DW:0] r_s, r_c;
            always_comb
            begin
                r_s = {rs_src, ls_src[BI]};
                r_c = {rc_src, lc_src[BI]};
                if (r_s >= {1'b0, ds_src})
                begin
                    rs_next = DW'(r_s - {1'b0, ds_src});
                    qs_next = {qs_src[QW-2:0], 1'b1};
                end
                else
                begin
                    rs_next = r_s[DW-1:0];
                    qs_next = {qs_src[QW-2:0], 1'b0};
                end
                if (r_c >= {1'b0, dc_src})
                begin
                    rc_next = DW'(r_c - {1'b0, dc_src});
                    qc_next = {qc_src[QW-2:0], 1'b1};
                end
                else
                begin
                    rc_next = r_c[DW-1:0];
                    qc_next = {qc_src[QW-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_nodiv
            assign rs_next = rs_src;
            assign qs_next = qs_src;
            assign rc_next = rc_src;
            assign qc_next = qc_src;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k]  <= st_src;
                dec_reg[k] <= dec_src;
                f_reg[k]   <= f_next;
                rs_reg[k]  <= rs_next;
                ds_reg[k]  <= ds_src;
                ls_reg[k]  <= ls_src;
                qs_reg[k]  <= qs_next;
                rc_reg[k]  <= rc_next;
                dc_reg[k]  <= dc_src;
                lc_reg[k]  <= lc_src;
                qc_reg[k]  <= qc_next;
                sd_reg[k]  <= sd_src;
            end
        end
    end

    assign out_valid = v_reg[L-1];
    assign out_f     = f_reg[L-1];
    assign out_q_s   = qs_reg[L-1];
    assign out_q_c   = qc_reg[L-1];
    assign out_side  = sd_reg[L-1];

endmodule

@@ hdl/truth_value_inference_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truth_value_inference_unit
// Evaluates one inference rule per transaction and returns a Q1.F
// strength/confidence pair.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink)  : rule code plus pairs a, b, ab, step count and decay rate.
//   rsp  (source): out_strength / out_confidence, both saturated to 1.0.
//   A transaction is taken when valid and ready are high at a clock edge.
//   Throughput: one transaction per cycle while rsp is ready.
//   A request passes stages 0 to 3, then a chain of L stages, where
//   L = max(2**STEP_BITS - 1, FRAC_BITS + 2), then the output register.
//   At the defaults, L is set by the decay chain (one truncated multiply per
//   whole step) running beside the bit-per-stage dividers.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When rsp stalls with a result waiting, the whole pipeline holds and
//   req.ready drops until the result is taken; no transaction is lost.
// ----------------------------------------------------------------------------
module truth_value_inference_unit #(
    parameter int FRAC_BITS = 16,
    parameter int STEP_BITS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    tvi_req_if.sink      req,
    tvi_rsp_if.source    rsp
);
    localparam int F      = FRAC_BITS;
    localparam int W      = FRAC_BITS + 1;
    localparam int DW     = FRAC_BITS + 2;
    localparam int QW     = FRAC_BITS + 2;
    localparam int NW     = 2 * FRAC_BITS + 2;
    localparam int SIDE_W = 1 + tvi_pkg::SRC_W + 2 * W + 1;
    localparam logic [W-1:0] ONE = W'(1) << F;
    localparam logic [W-1:0] K_DED = W'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [W-1:0] K_ABD = W'(((64'd17 << FRAC_BITS) + 64'd10) / 64'd20);
    localparam logic [W-1:0] K_IND = W'(((64'd4 << FRAC_BITS) + 64'd2) / 64'd5);

    logic pipe_en;
    logic out_v_reg;
    logic [W-1:0] out_s_reg, out_c_reg;

    assign pipe_en   = !out_v_reg || rsp.ready;
    assign req.ready = pipe_en;

    // stage 0: saturate inputs to 1.0
    logic                      v0_reg;
    logic [tvi_pkg::CMD_W-1:0] cmd0_reg;
    logic [W-1:0] as0_reg, ac0_reg, bs0_reg, bc0_reg, xs0_reg, xc0_reg, dec0_reg;
    logic [STEP_BITS-1:0] st0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v0_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            cmd0_reg <= req.cmd;
            as0_reg  <= (req.a_strength    > ONE) ? ONE : req.a_strength;
            ac0_reg  <= (req.a_confidence  > ONE) ? ONE : req.a_confidence;
            bs0_reg  <= (req.b_strength    > ONE) ? ONE : req.b_strength;
            bc0_reg  <= (req.b_confidence  > ONE) ? ONE : req.b_confidence;
            xs0_reg  <= (req.ab_strength   > ONE) ? ONE : req.ab_strength;
            xc0_reg  <= (req.ab_confidence > ONE) ? ONE : req.ab_confidence;
            dec0_reg <= (req.decay_rate    > ONE) ? ONE : req.decay_rate;
            st0_reg  <= req.step_count;
        end
    end

    // stage 1: first products
    logic [2*W-1:0] xa_prod, xc_prod, acbc_prod;
    logic v1_reg;
    logic [tvi_pkg::CMD_W-1:0] cmd1_reg;
    logic [W-1:0] as1_reg, ac1_reg, bs1_reg, bc1_reg, dec1_reg;
    logic [W-1:0] pxa1_reg, pxc1_reg, acbc1_reg;
    logic [NW-1:0] ra1_reg, rb1_reg;
    logic [DW-1:0] t1_reg;
    logic [STEP_BITS-1:0] st1_reg;

    always_comb
    begin
        xa_prod   = (2*W)'(xs0_reg) * (2*W)'(as0_reg);
        xc_prod   = (2*W)'(xc0_reg) * (2*W)'(ac0_reg);
        acbc_prod = (2*W)'(ac0_reg) * (2*W)'(bc0_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            cmd1_reg  <= cmd0_reg;
            as1_reg   <= as0_reg;
            ac1_reg   <= ac0_reg;
            bs1_reg   <= bs0_reg;
            bc1_reg   <= bc0_reg;
            dec1_reg  <= dec0_reg;
            st1_reg   <= st0_reg;
            pxa1_reg  <= xa_prod[F+W-1:F];
            pxc1_reg  <= xc_prod[F+W-1:F];
            acbc1_reg <= acbc_prod[F+W-1:F];
            ra1_reg   <= NW'((2*W)'(as0_reg) * (2*W)'(ac0_reg));
            rb1_reg   <= NW'((2*W)'(bs0_reg) * (2*W)'(bc0_reg));
            t1_reg    <= DW'(ac0_reg) + DW'(bc0_reg);
        end
    end

    // stage 2: constant scaling, revise numerator
    logic [2*W-1:0] ded_prod, abd1_prod, ind_prod;
    logic v2_reg;
    logic [tvi_pkg::CMD_W-1:0] cmd2_reg;
    logic [W-1:0] as2_reg, ac2_reg, bs2_reg, dec2_reg, pxa2_reg;
    logic [W-1:0] cded2_reg, cab2_reg, cind2_reg;
    logic [NW-1:0] nrev2_reg;
    logic [DW-1:0] t2_reg;
    logic [STEP_BITS-1:0] st2_reg;

    always_comb
    begin
        ded_prod  = (2*W)'(pxc1_reg) * (2*W)'(K_DED);
        abd1_prod = (2*W)'(pxc1_reg) * (2*W)'(bc1_reg);
        ind_prod  = (2*W)'(acbc1_reg) * (2*W)'(K_IND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            cmd2_reg  <= cmd1_reg;
            as2_reg   <= as1_reg;
            ac2_reg   <= ac1_reg;
            bs2_reg   <= bs1_reg;
            dec2_reg  <= dec1_reg;
            st2_reg   <= st1_reg;
            pxa2_reg  <= pxa1_reg;
            cded2_reg <= ded_prod[F+W-1:F];
            cab2_reg  <= abd1_prod[F+W-1:F];
            cind2_reg <= ind_prod[F+W-1:F];
            nrev2_reg <= ra1_reg + rb1_reg;
            t2_reg    <= t1_reg;
        end
    end

    // stage 3: rule select, divider setup
    logic [2*W-1:0]          abd_prod;
    logic [NW-1:0]           num_s, num_c;
    logic [DW-1:0]           den_s, den_c;
    logic                    ovf_s, s_div;
    logic [tvi_pkg::SRC_W-1:0] c_src;
    logic [W-1:0]            s_dir, c_dir;

    always_comb
    begin
        abd_prod = (2*W)'(cab2_reg) * (2*W)'(K_ABD);
        num_c    = {t2_reg, {F{1'b0}}};
        den_c    = t2_reg + DW'(ONE);
        num_s    = nrev2_reg;
        den_s    = t2_reg;
        s_div    = 1'b0;
        c_src    = tvi_pkg::SRC_DIRECT;
        s_dir    = '0;
        c_dir    = '0;
        unique case (cmd2_reg)
            tvi_pkg::CMD_DEDUCE:
            begin
                s_dir = pxa2_reg;
                c_dir = cded2_reg;
            end
            tvi_pkg::CMD_TEMPORAL:
            begin
                s_dir = pxa2_reg;
                c_dir = cded2_reg;
                c_src = tvi_pkg::SRC_DECAY;
            end
            tvi_pkg::CMD_REVISE:
            begin
                if (t2_reg == '0)
                begin
                    s_dir = as2_reg;
                    c_dir = ac2_reg;
                end
                else
                begin
                    s_div = 1'b1;
                    c_src = tvi_pkg::SRC_DIV;
                end
            end
            tvi_pkg::CMD_ABDUCE:
            begin
                num_s = NW'({pxa2_reg, {F{1'b0}}});
                den_s = DW'(bs2_reg);
                if (bs2_reg != '0)
                begin
                    s_div = 1'b1;
                    c_dir = abd_prod[F+W-1:F];
                end
            end
            tvi_pkg::CMD_INDUCE:
            begin
                num_s = NW'({bs2_reg, {F{1'b0}}});
                den_s = DW'(as2_reg);
                s_div = (as2_reg != '0);
                c_dir = cind2_reg;
            end
            default:
            begin
                s_dir = '0;
            end
        endcase
        ovf_s = DW'(num_s[NW-1:QW]) >= den_s;
    end

    logic v3_reg;
    logic [W-1:0] dec3_reg;
    logic [STEP_BITS-1:0] st3_reg;
    logic [DW-1:0] rs3_reg, ds3_reg, rc3_reg, dc3_reg;
    logic [QW-1:0] ls3_reg, lc3_reg;
    logic [SIDE_W-1:0] side3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dec3_reg  <= dec2_reg;
            st3_reg   <= st2_reg;
            rs3_reg   <= DW'(num_s[NW-1:QW]);
            ds3_reg   <= den_s;
            ls3_reg   <= num_s[QW-1:0];
            rc3_reg   <= DW'(num_c[NW-1:QW]);
            dc3_reg   <= den_c;
            lc3_reg   <= num_c[QW-1:0];
            side3_reg <= {s_div, c_src, s_dir, c_dir, ovf_s};
        end
    end

    // decay chain and dividers
    logic              ch_valid;
    logic [W-1:0]      ch_f;
    logic [QW-1:0]     ch_q_s, ch_q_c;
    logic [SIDE_W-1:0] ch_side;

    tvi_chain #(
        .FRAC_BITS (FRAC_BITS),
        .STEP_BITS (STEP_BITS),
        .SIDE_W    (SIDE_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (v3_reg),
        .in_steps  (st3_reg),
        .in_decay  (dec3_reg),
        .in_rem_s  (rs3_reg),
        .in_den_s  (ds3_reg),
        .in_lo_s   (ls3_reg),
        .in_rem_c  (rc3_reg),
        .in_den_c  (dc3_reg),
        .in_lo_c   (lc3_reg),
        .in_side   (side3_reg),
        .out_valid (ch_valid),
        .out_f     (ch_f),
        .out_q_s   (ch_q_s),
        .out_q_c   (ch_q_c),
        .out_side  (ch_side)
    );

    // output stage
    logic                      f_s_div, f_ovf;
    logic [tvi_pkg::SRC_W-1:0] f_c_src;
    logic [W-1:0]              f_s_dir, f_c_dir, s_next, c_next;
    logic [2*W-1:0]            decay_prod;

    always_comb
    begin
        {f_s_div, f_c_src, f_s_dir, f_c_dir, f_ovf} = ch_side;
        decay_prod = (2*W)'(f_c_dir) * (2*W)'(ch_f);
        if (!f_s_div)
        begin
            s_next = f_s_dir;
        end
        else if (f_ovf || ch_q_s > QW'(ONE))
        begin
            s_next = ONE;
        end
        else
        begin
            s_next = ch_q_s[W-1:0];
        end
        unique case (f_c_src)
            tvi_pkg::SRC_DIV:   c_next = (ch_q_c > QW'(ONE)) ? ONE : ch_q_c[W-1:0];
            tvi_pkg::SRC_DECAY: c_next = decay_prod[F+W-1:F];
            default:            c_next = f_c_dir;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_v_reg <= ch_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_s_reg <= s_next;
            out_c_reg <= c_next;
        end
    end

    assign rsp.valid          = out_v_reg;
    assign rsp.out_strength   = out_s_reg;
    assign rsp.out_confidence = out_c_reg;

    a_strength_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> out_s_reg <= ONE)
        else $error("strength above one");

    a_confidence_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> out_c_reg <= ONE)
        else $error("confidence above one");

    a_stall_holds_front: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(v3_reg) && $stable(side3_reg))
        else $error("front stages moved during stall");

    a_div_no_overflow_c: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid && f_c_src == tvi_pkg::SRC_DIV |-> ch_q_c < QW'(ONE))
        else $error("revise confidence quotient out of range");

endmodule
